FILE: hdl/tti_pkg.sv
// Shared types, constants and CORDIC helpers for the tilt-table inverse kinematics unit.
`default_nettype none

package tti_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TBL_LEN          = 24;
  localparam int SQRT_STEPS       = 15;
  localparam int SQRT_TOP         = 28;
  localparam int XW               = 35;
  localparam int ZW               = 28;

  typedef logic signed [XW-1:0] cx_t;
  typedef logic signed [ZW-1:0] cz_t;
  typedef logic signed [18:0]   ang_t;

  localparam cz_t  DEG90_FINE = 28'sd23592960;
  localparam ang_t B_MAX      = 19'sd92160;
  localparam ang_t C_MAX      = 19'sd184320;
  localparam logic signed [19:0] B_LIMIT = 20'sd112640;
  localparam logic signed [19:0] C_LIMIT = 20'sd368640;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam cz_t STEP_ANGLE [TBL_LEN] = '{
    28'sd11796480, 28'sd6963869, 28'sd3679517, 28'sd1867780, 28'sd937515, 28'sd469214,
    28'sd234664, 28'sd117339, 28'sd58671, 28'sd29335, 28'sd14668, 28'sd7334,
    28'sd3667, 28'sd1833, 28'sd917, 28'sd458, 28'sd229, 28'sd115,
    28'sd57, 28'sd29, 28'sd14, 28'sd7, 28'sd4, 28'sd2
  };

  typedef enum logic [1:0] {
    REG_AXIS  = 2'd0,
    REG_ENV_X = 2'd1,
    REG_ENV_Y = 2'd2,
    REG_ENV_Z = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cx_t x;
    cx_t y;
    cz_t z;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic signed [15:0] xc;
  } sq_side_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic               b_spec;
    ang_t               b_val;
    logic               c_spec;
    ang_t               c_val;
    logic               c_zero;
  } cd_side_t;

  function automatic rot_t cordic_step(rot_t r, int unsigned i);
    rot_t o;
    cx_t  xs;
    cx_t  ys;
    xs = r.x >>> i;
    ys = r.y >>> i;
    if (r.y > 0) begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + STEP_ANGLE[i];
    end else begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - STEP_ANGLE[i];
    end
    return o;
  endfunction

  function automatic rot_t atan_prep(logic signed [17:0] y, logic signed [17:0] x);
    rot_t o;
    cx_t  xs;
    cx_t  ys;
    xs = cx_t'(x) <<< 16;
    ys = cx_t'(y) <<< 16;
    if (xs < 0) begin
      if (ys >= 0) begin
        o.x = ys;
        o.y = -xs;
        o.z = DEG90_FINE;
      end else begin
        o.x = -ys;
        o.y = xs;
        o.z = -DEG90_FINE;
      end
    end else begin
      o.x = xs;
      o.y = ys;
      o.z = '0;
    end
    return o;
  endfunction

  function automatic logic atan_is_spec(logic signed [17:0] y, logic signed [17:0] x);
    return (y == 18'sd0) || (x == 18'sd0);
  endfunction

  function automatic ang_t atan_spec_val(logic signed [17:0] y, logic signed [17:0] x);
    ang_t v;
    if (y == 18'sd0) begin
      v = (x < 0) ? C_MAX : '0;
    end else begin
      v = (y > 0) ? B_MAX : -B_MAX;
    end
    return v;
  endfunction

  function automatic ang_t angle_final(cz_t z, logic spec, ang_t sval, ang_t lim);
    cz_t               t;
    logic signed [19:0] r;
    logic signed [19:0] l;
    ang_t              o;
    t = z + cz_t'(128);
    r = 20'(t >>> 8);
    if (spec) begin
      r = 20'(sval);
    end
    l = 20'(lim);
    if (r > l) begin
      o = lim;
    end else if (r < -l) begin
      o = -lim;
    end else begin
      o = 19'(r);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tti_sqrt_cell.sv
// One digit cell of the pipelined integer square root for cos B.
`default_nettype none

module tti_sqrt_cell #(
  parameter int SHIFT = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vin,
  input  logic [28:0]      n_in,
  input  logic [29:0]      root_in,
  input  tti_pkg::sq_side_t side_in,
  output logic             vout,
  output logic [28:0]      n_out,
  output logic [29:0]      root_out,
  output tti_pkg::sq_side_t side_out
);
  import tti_pkg::*;

  localparam logic [29:0] BIT = 30'(1) << SHIFT;

  logic        v_r, v_nxt;
  logic [28:0] n_r, n_nxt;
  logic [29:0] root_r, root_nxt;
  sq_side_t    side_r;
  logic [29:0] trial;

  always_comb begin
    trial = root_in + BIT;
    if ({1'b0, n_in} >= trial) begin
      n_nxt    = 29'({1'b0, n_in} - trial);
      root_nxt = (root_in >> 1) + BIT;
    end else begin
      n_nxt    = n_in;
      root_nxt = root_in >> 1;
    end
    v_nxt = en ? vin : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      root_r <= root_nxt;
      side_r <= side_in;
    end
  end

  assign vout     = v_r;
  assign n_out    = n_r;
  assign root_out = root_r;
  assign side_out = side_r;

endmodule

`default_nettype wire

FILE: hdl/tti_cordic_cell.sv
// One CORDIC vectoring cell, turning the B and C vectors by one table angle.
`default_nettype none

module tti_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vin,
  input  tti_pkg::rot_t     b_in,
  input  tti_pkg::rot_t     c_in,
  input  tti_pkg::cd_side_t side_in,
  output logic              vout,
  output tti_pkg::rot_t     b_out,
  output tti_pkg::rot_t     c_out,
  output tti_pkg::cd_side_t side_out
);
  import tti_pkg::*;

  logic     v_r, v_nxt;
  rot_t     b_r, b_nxt;
  rot_t     c_r, c_nxt;
  cd_side_t side_r;

  always_comb begin
    b_nxt = cordic_step(b_in, STEP);
    c_nxt = cordic_step(c_in, STEP);
    v_nxt = en ? vin : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      side_r <= side_in;
    end
  end

  assign vout     = v_r;
  assign b_out    = b_r;
  assign c_out    = c_r;
  assign side_out = side_r;

endmodule

`default_nettype wire

FILE: hdl/tilt_table_inverse_kinematics_unit.sv
// Top level of the tilt-table B/C inverse kinematics unit.
//
//   port group | direction | word
//   in_*       | in        | tool tip X/Y/Z and tool axis vector
//   out_*      | out       | X/Y/Z command, B and C angles, limit flag
//   cfg_*      | in        | axis count and work envelope registers
//
// One word enters per cycle while in_ready is high. Stages in order: input register,
// 15 square-root cells, prerotation register, CORDIC cell chain, output register.
// Each stage advances when its successor has room, so bubbles close up under stall.
// Synchronous active-low reset clears valid bits and loads register defaults.
`default_nettype none

module tilt_table_inverse_kinematics_unit #(
  parameter int CORDIC_STEPS = tti_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_tip_x,
  input  logic signed [31:0] in_tip_y,
  input  logic signed [31:0] in_tip_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [17:0] out_angle_b,
  output logic signed [18:0] out_angle_c,
  output logic               out_within_limits,
  input  logic               cfg_wr_en,
  input  tti_pkg::reg_idx_t  cfg_index,
  input  logic [30:0]        cfg_data
);
  import tti_pkg::*;

  localparam int SQ0 = 1;
  localparam int PRE = SQ0 + SQRT_STEPS;
  localparam int CD0 = PRE + 1;
  localparam int NST = CD0 + CORDIC_STEPS;

  logic [2:0]  axis_count_r;
  logic [30:0] env_x_r, env_y_r, env_z_r;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  // stage 0
  logic               v0_r;
  logic [28:0]        n0_r;
  sq_side_t           side0_r;
  logic signed [15:0] xc;
  logic signed [31:0] xsq;

  logic [28:0] sq_n    [SQRT_STEPS+1];
  logic [29:0] sq_root [SQRT_STEPS+1];
  sq_side_t    sq_side [SQRT_STEPS+1];

  // prerotation stage
  logic               vp_r;
  rot_t               bp_r, cp_r;
  cd_side_t           sidep_r;
  logic signed [17:0] b_y, b_x, c_y, c_x;

  rot_t     cd_b    [CORDIC_STEPS+1];
  rot_t     cd_c    [CORDIC_STEPS+1];
  cd_side_t cd_side [CORDIC_STEPS+1];

  // output register
  logic               out_valid_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [17:0] angle_b_r;
  logic signed [18:0] angle_c_r;
  logic               within_r;

  cd_side_t           fs;
  ang_t               b_fin, c_fin;
  logic               ok_x, ok_y, ok_z, ok_bc, five_ax, tilt_on;
  logic [32:0]        neg_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= 3'd5;
      env_x_r      <= 31'd1000000;
      env_y_r      <= 31'd1000000;
      env_z_r      <= 31'd500000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AXIS:  axis_count_r <= cfg_data[2:0];
        REG_ENV_X: env_x_r      <= cfg_data;
        REG_ENV_Y: env_y_r      <= cfg_data;
        REG_ENV_Z: env_z_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[NST] = !out_valid_r || out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    if (in_dir_x > ONE_Q14) begin
      xc = ONE_Q14;
    end else if (in_dir_x < -ONE_Q14) begin
      xc = -ONE_Q14;
    end else begin
      xc = in_dir_x;
    end
    xsq = xc * xc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy[0]) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      n0_r       <= 29'(32'sd268435456 - xsq);
      side0_r.tx <= in_tip_x;
      side0_r.ty <= in_tip_y;
      side0_r.tz <= in_tip_z;
      side0_r.dy <= in_dir_y;
      side0_r.dz <= in_dir_z;
      side0_r.xc <= xc;
    end
  end

  assign v[0]       = v0_r;
  assign sq_n[0]    = n0_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = side0_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tti_sqrt_cell #(
      .SHIFT(SQRT_TOP - 2 * k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (rdy[SQ0+k]),
      .vin     (v[SQ0+k-1]),
      .n_in    (sq_n[k]),
      .root_in (sq_root[k]),
      .side_in (sq_side[k]),
      .vout    (v[SQ0+k]),
      .n_out   (sq_n[k+1]),
      .root_out(sq_root[k+1]),
      .side_out(sq_side[k+1])
    );
  end

  always_comb begin
    b_y = 18'(sq_side[SQRT_STEPS].xc);
    b_x = {3'b000, sq_root[SQRT_STEPS][14:0]};
    c_y = -18'(sq_side[SQRT_STEPS].dy);
    c_x = 18'(sq_side[SQRT_STEPS].dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (rdy[PRE]) begin
      vp_r <= v[PRE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[PRE]) begin
      bp_r           <= atan_prep(b_y, b_x);
      cp_r           <= atan_prep(c_y, c_x);
      sidep_r.tx     <= sq_side[SQRT_STEPS].tx;
      sidep_r.ty     <= sq_side[SQRT_STEPS].ty;
      sidep_r.tz     <= sq_side[SQRT_STEPS].tz;
      sidep_r.b_spec <= atan_is_spec(b_y, b_x);
      sidep_r.b_val  <= atan_spec_val(b_y, b_x);
      sidep_r.c_spec <= atan_is_spec(c_y, c_x);
      sidep_r.c_val  <= atan_spec_val(c_y, c_x);
      sidep_r.c_zero <= (sq_side[SQRT_STEPS].xc == ONE_Q14) ||
                        (sq_side[SQRT_STEPS].xc == -ONE_Q14);
    end
  end

  assign v[PRE]     = vp_r;
  assign cd_b[0]    = bp_r;
  assign cd_c[0]    = cp_r;
  assign cd_side[0] = sidep_r;

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    tti_cordic_cell #(
      .STEP(s)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (rdy[CD0+s]),
      .vin     (v[CD0+s-1]),
      .b_in    (cd_b[s]),
      .c_in    (cd_c[s]),
      .side_in (cd_side[s]),
      .vout    (v[CD0+s]),
      .b_out   (cd_b[s+1]),
      .c_out   (cd_c[s+1]),
      .side_out(cd_side[s+1])
    );
  end

  always_comb begin
    fs      = cd_side[CORDIC_STEPS];
    tilt_on = axis_count_r > 3'd3;
    five_ax = axis_count_r >= 3'd5;
    b_fin   = angle_final(cd_b[CORDIC_STEPS].z, fs.b_spec, fs.b_val, B_MAX);
    c_fin   = angle_final(cd_c[CORDIC_STEPS].z, fs.c_spec, fs.c_val, C_MAX);
    if (fs.c_zero) begin
      c_fin = '0;
    end
    if (!tilt_on) begin
      b_fin = '0;
      c_fin = '0;
    end
    ok_x  = !fs.tx[31] && (fs.tx[30:0] <= env_x_r);
    ok_y  = !fs.ty[31] && (fs.ty[30:0] <= env_y_r);
    neg_z = 33'd0 - {fs.tz[31], fs.tz};
    ok_z  = (fs.tz == 32'sd0) || (fs.tz[31] && (neg_z <= {2'b00, env_z_r}));
    ok_bc = !five_ax ||
            ((20'(b_fin) >= -B_LIMIT) && (20'(b_fin) <= B_LIMIT) &&
             (20'(c_fin) >= -C_LIMIT) && (20'(c_fin) <= C_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NST]) begin
      out_valid_r <= v[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST] && v[NST-1]) begin
      pos_x_r   <= fs.tx;
      pos_y_r   <= fs.ty;
      pos_z_r   <= fs.tz;
      angle_b_r <= 18'(b_fin);
      angle_c_r <= c_fin;
      within_r  <= !tilt_on || (ok_x && ok_y && ok_z && ok_bc);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = pos_x_r;
  assign out_pos_y         = pos_y_r;
  assign out_pos_z         = pos_z_r;
  assign out_angle_b       = angle_b_r;
  assign out_angle_c       = angle_c_r;
  assign out_within_limits = within_r;

  a_plain_xyz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (axis_count_r <= 3'd3) |->
      (angle_b_r == 18'sd0) && (angle_c_r == 19'sd0) && within_r)
    else $error("plain XYZ word carries nonzero angle or limit fault");

  a_b_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (angle_b_r <= 18'sd92160) && (angle_b_r >= -18'sd92160))
    else $error("B angle outside saturation range");

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v[0])
    else $error("accepted word missing from first stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v[NST-1] && rdy[NST] |=> out_valid_r)
    else $error("last stage word not moved to output register");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the tilt-table inverse kinematics unit.
`timescale 1ns / 1ps

class kin_scoreboard;
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [17:0] b;
    logic signed [18:0] c;
    logic               ok;
  } move_t;

  int unsigned axes = 5;
  longint      env_x = 1000000;
  longint      env_y = 1000000;
  longint      env_z = 500000;
  move_t       pending[$];
  int          errors = 0;

  static longint step_angle[24] = '{
    11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7, 4, 2
  };

  function longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function longint int_sqrt(longint n);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'd1 << 30;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - root - bitv;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function longint arctan2(longint y, longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (y == 0) return (x < 0) ? 184320 : 0;
    if (x == 0) return (y > 0) ? 92160 : -92160;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 23592960;
      end else begin
        t = x; x = -y; y = t; z = -23592960;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += step_angle[i];
      end else begin
        x -= ys; y += xs; z -= step_angle[i];
      end
    end
    return shr(z + 128, 8);
  endfunction

  function longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function void note_move(logic signed [31:0] tx, logic signed [31:0] ty,
                          logic signed [31:0] tz, logic signed [15:0] dx,
                          logic signed [15:0] dy, logic signed [15:0] dz);
    move_t  m;
    longint xc;
    longint cb;
    longint b;
    longint c;
    m.px = tx; m.py = ty; m.pz = tz;
    b = 0; c = 0; m.ok = 1;
    if (axes > 3) begin
      xc = dx;
      if (xc > 16384) xc = 16384;
      if (xc < -16384) xc = -16384;
      cb = int_sqrt(64'd268435456 - xc * xc);
      b = clip(arctan2(xc, cb), 92160);
      if (xc != 16384 && xc != -16384) c = clip(arctan2(-longint'(dy), dz), 184320);
      if (tx < 0 || longint'(tx) > env_x) m.ok = 0;
      if (ty < 0 || longint'(ty) > env_y) m.ok = 0;
      if (longint'(tz) < -env_z || tz > 0) m.ok = 0;
      if (axes >= 5) begin
        if (b < -112640 || b > 112640) m.ok = 0;
        if (c < -368640 || c > 368640) m.ok = 0;
      end
    end
    m.b = b[17:0];
    m.c = c[18:0];
    pending = {pending, m};
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_move(move_t r);
    move_t e;
    if (pending.size() == 0) begin
      $display("mismatch: unexpected word");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (r.px !== e.px) report("pos_x", r.px, e.px);
    if (r.py !== e.py) report("pos_y", r.py, e.py);
    if (r.pz !== e.pz) report("pos_z", r.pz, e.pz);
    if (r.b !== e.b) report("angle_b", r.b, e.b);
    if (r.c !== e.c) report("angle_c", r.c, e.c);
    if (r.ok !== e.ok) report("within_limits", r.ok, e.ok);
  endtask
endclass

module tb_top;
  import tti_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_tip_x, in_tip_y, in_tip_z;
  logic signed [15:0] in_dir_x, in_dir_y, in_dir_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [17:0] out_angle_b;
  logic signed [18:0] out_angle_c;
  logic               out_within_limits;
  logic               cfg_wr_en;
  reg_idx_t           cfg_index;
  logic [30:0]        cfg_data;

  kin_scoreboard moves;
  int            rx_idle_pct;
  int            rx_hold;
  bit            hold_req;
  bit            hold_taken;
  bit            done;

  tilt_table_inverse_kinematics_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  task send_move(logic signed [31:0] tx, logic signed [31:0] ty, logic signed [31:0] tz,
                 logic signed [15:0] dx, logic signed [15:0] dy, logic signed [15:0] dz,
                 int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_tip_x <= tx; in_tip_y <= ty; in_tip_z <= tz;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    do @(posedge clk); while (!in_ready);
    moves.note_move(tx, ty, tz, dx, dy, dz);
  endtask

  task write_reg(reg_idx_t idx, logic [30:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    case (idx)
      REG_AXIS:  moves.axes = val[2:0];
      REG_ENV_X: moves.env_x = val;
      REG_ENV_Y: moves.env_y = val;
      REG_ENV_Z: moves.env_z = val;
      default: ;
    endcase
  endtask

  task drain;
    in_valid <= 0;
    @(posedge clk);
    while (moves.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function logic signed [15:0] rand_dir();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(32767, 16384));
      2: return -16'($urandom_range(32768, 16384));
      3: return 16'($urandom_range(3)) - 16'sd1;
      default: return 16'($urandom_range(32768)) - 16'sd16384;
    endcase
  endfunction

  function logic signed [31:0] rand_pos(longint env);
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'(longint'($urandom_range(32'(env))));
      2: return 32'(longint'($urandom_range(2)) + env - 1);
      default: return 32'($urandom_range(2)) - 1;
    endcase
  endfunction

  task random_phase(int count, int idle_pct);
    logic signed [31:0] tz;
    for (int i = 0; i < count; i++) begin
      tz = -rand_pos(moves.env_z);
      if ($urandom_range(7) == 0) tz = $urandom;
      send_move(rand_pos(moves.env_x), rand_pos(moves.env_y), tz,
                rand_dir(), rand_dir(), rand_dir(), idle_pct);
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      rx_hold <= 0;
      hold_taken <= 0;
    end else begin
      if (out_valid && out_ready)
        moves.check_move('{out_pos_x, out_pos_y, out_pos_z, out_angle_b, out_angle_c,
                           out_within_limits});
      if (hold_req && !hold_taken) begin
        hold_taken <= 1;
        rx_hold <= 200;
        out_ready <= 0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= 0;
      end else begin
        out_ready <= done || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    moves = new();
    rst_n = 0; in_valid = 0; cfg_wr_en = 0; cfg_index = REG_AXIS; cfg_data = 0;
    in_tip_x = 0; in_tip_y = 0; in_tip_z = 0; in_dir_x = 0; in_dir_y = 0; in_dir_z = 0;
    rx_idle_pct = 15; done = 0; hold_req = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // corners at reset settings
    send_move(0, 0, 0, 16384, 0, 0, 0);
    send_move(0, 0, 0, -16384, 5, 7, 0);
    send_move(0, 0, 0, 32767, -32768, 32767, 0);
    send_move(0, 0, 0, -32768, 32767, -32768, 0);
    send_move(1000000, 1000000, -500000, 0, 0, -16384, 0);
    send_move(1000001, 0, 0, 0, 0, 16384, 0);
    send_move(-1, -1, 1, 0, 16384, 0, 0);
    send_move(0, 1000001, -500001, 0, -16384, 0, 0);
    send_move(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
    send_move(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 11585, 100, -100, 0);
    send_move(5, 5, -5, -11585, -100, -100, 0);
    send_move(5, 5, -5, 1, -1, 1, 0);
    send_move(5, 5, -5, 0, 32767, -32768, 0);
    random_phase(100, 15);
    drain();

    write_reg(REG_AXIS, 3);
    write_reg(REG_ENV_X, 0);
    write_reg(REG_ENV_Y, 31'h7fffffff);
    write_reg(REG_ENV_Z, 0);
    send_move(0, 0, 0, 16384, 0, 0, 0);
    send_move(-1, 5, 1, 3, 4, 5, 0);
    random_phase(80, 15);
    drain();

    write_reg(REG_AXIS, 4);
    random_phase(100, 15);
    drain();

    // long receiver stall while the sender keeps offering
    write_reg(REG_AXIS, 7);
    write_reg(REG_ENV_X, 31'h7fffffff);
    write_reg(REG_ENV_Z, 31'h7fffffff);
    write_reg(REG_ENV_Y, 1234);
    hold_req <= 1;
    random_phase(100, 0);
    drain();

    write_reg(REG_AXIS, 0);
    random_phase(40, 15);
    drain();

    write_reg(REG_AXIS, 5);
    write_reg(REG_ENV_X, 1000000);
    write_reg(REG_ENV_Y, 1000000);
    write_reg(REG_ENV_Z, 500000);
    rx_idle_pct = 0;
    random_phase(100, 0);
    rx_idle_pct = 15;
    random_phase(80, 15);
    done = 1;
    drain();

    if (moves.errors == 0 && moves.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
